/* sv/breakpoint_table_linear_interp_unit_macros.svh */
// Assertion macros shared by the checker
`ifndef BREAKPOINT_TABLE_LINEAR_INTERP_UNIT_MACROS_SVH
`define BREAKPOINT_TABLE_LINEAR_INTERP_UNIT_MACROS_SVH

`define BTLI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BTLI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/btli_pkg.sv */
`default_nettype none
package btli_pkg;
  localparam int unsigned DefDepth = 64;
  localparam int unsigned DataW = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NOSEG = 2'd2;

  // divider request from the sequencer
  typedef struct packed {
    logic        start;
    logic [32:0] num;   // signed numerator (q-x0)*(y1-y0)
    logic [16:0] den;   // positive denominator x1-x0
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;   // signed quotient, truncated toward zero
  } div_rsp_t;
endpackage
`default_nettype wire

/* sv/btli_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle on magnitudes
module btli_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire btli_pkg::div_req_t req,
  output btli_pkg::div_rsp_t     rsp
);
  import btli_pkg::*;

  logic [32:0] quo;
  logic [17:0] rem;
  logic [16:0] den;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic        done;
  logic [17:0] trial;
  logic [32:0] mag;

  assign mag   = req.num[32] ? (~req.num + 33'd1) : req.num;
  assign trial = {rem[16:0], quo[32]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd33;
        quo  <= mag;
        rem  <= '0;
        den  <= req.den;
        neg  <= req.num[32];
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quo <= {quo[31:0], 1'b1};
        end else begin
          rem <= {rem[16:0], quo[32]};
          quo <= {quo[31:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = neg ? (~quo + 33'd1) : quo;
endmodule
`default_nettype wire

/* sv/btli_seq.sv */
`default_nettype none
// Sequencer: table memory, selection sort, segment scan, interpolation
module btli_seq #(
  parameter int unsigned TABLE_DEPTH = btli_pkg::DefDepth
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_go,
  input  wire logic               in_op,
  input  wire logic signed [15:0] in_x,
  input  wire logic signed [15:0] in_y,
  output logic                    idle,
  output logic                    res_valid,
  output logic signed [15:0]      res_y,
  output logic [1:0]              res_st,
  output btli_pkg::div_req_t      dreq,
  input  wire btli_pkg::div_rsp_t drsp
);
  import btli_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [15:0] {
    S_IDLE = 16'b0000000000000001,
    S_SI   = 16'b0000000000000010,  // start outer pass, read i
    S_SIW  = 16'b0000000000000100,
    S_SJ   = 16'b0000000000001000,  // take entry i, read first j
    S_SJW  = 16'b0000000000010000,
    S_SJC  = 16'b0000000000100000,  // compare entry j
    S_SW1  = 16'b0000000001000000,  // write swap
    S_SW2  = 16'b0000000010000000,
    S_QF   = 16'b0000000100000000,  // read first/last
    S_QFW  = 16'b0000001000000000,
    S_QL   = 16'b0000010000000000,
    S_QLC  = 16'b0000100000000000,
    S_QSW  = 16'b0001000000000000,  // segment scan
    S_QSC  = 16'b0010000000000000,
    S_MUL  = 16'b0100000000000000,
    S_DIV  = 16'b1000000000000000
  } state_t;

  state_t state;
  logic signed [15:0] xmem [TABLE_DEPTH];
  logic signed [15:0] ymem [TABLE_DEPTH];
  logic [AW-1:0] ra, wa;
  logic signed [15:0] rx, ry;
  logic we;
  logic signed [15:0] wx, wy;

  logic [CW-1:0] count;
  logic [CW-1:0] last;
  logic sorted;
  logic [CW-1:0] i, j;
  logic [AW-1:0] lo;
  logic signed [15:0] lox, loy, ix, iy, q, x0, y0;
  logic signed [16:0] dx, dy, dq;
  logic signed [32:0] prod;
  logic dstart;

  always_ff @(posedge clk) begin
    if (we) begin
      xmem[wa] <= wx;
      ymem[wa] <= wy;
    end
    rx <= xmem[ra];
    ry <= ymem[ra];
  end

  assign last = count - CW'(1);
  assign idle = (state == S_IDLE);

  always_comb begin
    dreq.start = dstart;
    dreq.num   = prod;
    dreq.den   = dx;
  end

  always_ff @(posedge clk) begin
    we        <= 1'b0;
    res_valid <= 1'b0;
    dstart    <= 1'b0;
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      sorted <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_go) begin
            if (in_op == OP_LOAD) begin
              if (count < CW'(TABLE_DEPTH)) begin
                we <= 1'b1; wa <= count[AW-1:0]; wx <= in_x; wy <= in_y;
                count <= count + CW'(1);
                sorted <= 1'b0;
              end
            end else begin
              q <= in_x;
              i <= '0;
              state <= sorted ? S_QF : S_SI;
            end
          end
        end
        S_SI: begin
          if (i >= count) begin
            sorted <= 1'b1;
            state <= S_QF;
          end else begin
            ra <= i[AW-1:0];
            lo <= i[AW-1:0];
            j <= i + CW'(1);
            state <= S_SIW;
          end
        end
        S_SIW: state <= S_SJ;
        S_SJ: begin
          // rx/ry hold entry i
          lox <= rx; loy <= ry; ix <= rx; iy <= ry;
          if (j < count) begin
            ra <= j[AW-1:0];
            state <= S_SJW;
          end else begin
            state <= S_SW1;
          end
        end
        S_SJW: state <= S_SJC;
        S_SJC: begin
          // strict compare keeps the earliest minimum
          if (rx < lox) begin
            lox <= rx; loy <= ry; lo <= j[AW-1:0];
          end
          j <= j + CW'(1);
          if (j + CW'(1) < count) begin
            ra <= AW'(j + CW'(1));
            state <= S_SJW;
          end else begin
            state <= S_SW1;
          end
        end
        S_SW1: begin
          // entry i <- lo, entry lo <- i
          we <= 1'b1; wa <= i[AW-1:0]; wx <= lox; wy <= loy;
          state <= S_SW2;
        end
        S_SW2: begin
          we <= 1'b1; wa <= lo; wx <= ix; wy <= iy;
          i <= i + CW'(1);
          state <= S_SI;
        end
        S_QF: begin
          if (count == '0) begin
            res_valid <= 1'b1; res_y <= '0; res_st <= ST_RANGE;
            state <= S_IDLE;
          end else begin
            ra <= '0;
            state <= S_QFW;
          end
        end
        S_QFW: begin
          ra <= last[AW-1:0];
          state <= S_QL;
        end
        S_QL: begin
          x0 <= rx; y0 <= ry;
          state <= S_QLC;
        end
        S_QLC: begin
          // rx holds the last x
          if (q < x0 || q > rx) begin
            res_valid <= 1'b1; res_y <= '0; res_st <= ST_RANGE;
            state <= S_IDLE;
          end else if (count > CW'(1)) begin
            ra <= AW'(1);
            j <= CW'(1);
            state <= S_QSW;
          end else begin
            res_valid <= 1'b1; res_y <= '0; res_st <= ST_NOSEG;
            state <= S_IDLE;
          end
        end
        S_QSW: state <= S_QSC;
        S_QSC: begin
          // x0/y0 hold entry j-1, rx/ry entry j
          if (q >= x0 && q <= rx) begin
            if (rx == x0) begin
              res_valid <= 1'b1; res_y <= y0; res_st <= ST_OK;
              state <= S_IDLE;
            end else begin
              dx <= 17'(rx) - 17'(x0);
              dy <= 17'(ry) - 17'(y0);
              dq <= 17'(q) - 17'(x0);
              state <= S_MUL;
            end
          end else begin
            x0 <= rx; y0 <= ry;
            j <= j + CW'(1);
            if (j + CW'(1) < count) begin
              ra <= AW'(j + CW'(1));
              state <= S_QSW;
            end else begin
              res_valid <= 1'b1; res_y <= '0; res_st <= ST_NOSEG;
              state <= S_IDLE;
            end
          end
        end
        S_MUL: begin
          prod <= 33'(dq) * 33'(dy);
          dstart <= 1'b1;
          state <= S_DIV;
        end
        S_DIV: begin
          if (drsp.done) begin
            res_valid <= 1'b1;
            res_y <= y0 + drsp.quo[15:0];
            res_st <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/breakpoint_table_linear_interp_unit.sv */
`default_nettype none
// channel   dir  fields (low bit up)
// s_axis    in   tuser=opcode, tdata=x_value[15:0], y_value[31:16]
// m_axis    out  tuser=status, tdata=y_result[15:0]
// A query sorts the table first if entries were stored since the last query,
// then checks the range and scans the segments; for a point inside a segment
// of nonzero width it forms the product and runs the 33-step shift-subtract
// divide. The result beat is registered from the sequencer result.
// Input is not ready while an item is at work or a result beat waits.
// Reset empties the table.
module breakpoint_table_linear_interp_unit #(
  parameter int unsigned TABLE_DEPTH = btli_pkg::DefDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // x_value, y_value
  input  wire logic        s_axis_tuser,   // opcode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // y_result
  output logic [1:0]       m_axis_tuser    // status
);
  import btli_pkg::*;

  logic idle, rv, busy;
  logic signed [15:0] ry;
  logic [1:0] rs;
  div_req_t dreq;
  div_rsp_t drsp;
  logic go;

  assign s_axis_tready = idle && !busy && !rv && !m_axis_tvalid;
  assign go = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      busy <= go;
      if (rv) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata <= ry;
        m_axis_tuser <= rs;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  btli_seq #(.TABLE_DEPTH(TABLE_DEPTH)) u_seq (
    .clk, .rst, .in_go(go), .in_op(s_axis_tuser),
    .in_x(s_axis_tdata[15:0]), .in_y(s_axis_tdata[31:16]),
    .idle, .res_valid(rv), .res_y(ry), .res_st(rs), .dreq, .drsp
  );

  btli_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));
endmodule
`default_nettype wire

/* sv/btli_chk.sv */
`default_nettype none
`include "breakpoint_table_linear_interp_unit_macros.svh"
module btli_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);
  import btli_pkg::*;

  `BTLI_ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat dropped")
  `BTLI_ASSERT_IMPL(a_excl, clk, rst, m_axis_tvalid, !s_axis_tready, "input taken while result waits")
  `BTLI_ASSERT_IMPL(a_zero, clk, rst, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == '0, "nonzero y with bad status")
  `BTLI_ASSERT_NEXT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready, !s_axis_tready, "back to back accept")
endmodule

bind breakpoint_table_linear_interp_unit btli_chk u_chk (.*);
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btli_pkg::*;

  localparam int Depth = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // x_value, y_value
  logic        s_axis_tuser = 1'b0; // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // y_result
  logic [1:0]  m_axis_tuser;        // status

  breakpoint_table_linear_interp_unit dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic        op;
    logic [15:0] xv;
    logic [15:0] yv;
  } beat_t;

  typedef struct packed {
    logic [15:0] yr;
    logic [1:0]  st;
  } answer_t;

  typedef struct {
    beat_t   b;
    bit      fixed;
    answer_t ans;
  } row_t;

  // own copy of the breakpoint store
  int  bp_x[Depth];
  int  bp_y[Depth];
  int  bp_n;
  bit  bp_sorted;

  answer_t pending_q[$];
  beat_t   feed_q[$];
  bit      fixed_q[$];
  answer_t fixed_ans_q[$];
  int      mismatches;
  bit      stim_done;
  bit      hold_long;

  function automatic void order_table();
    int lo, t;
    for (int i = 0; i < bp_n; i++) begin
      lo = i;
      for (int j = i + 1; j < bp_n; j++)
        if (bp_x[j] < bp_x[lo]) lo = j;
      t = bp_x[i]; bp_x[i] = bp_x[lo]; bp_x[lo] = t;
      t = bp_y[i]; bp_y[i] = bp_y[lo]; bp_y[lo] = t;
    end
  endfunction

  // updates the store; returns 1 and the answer when the beat is a query
  function automatic bit interpolate(input beat_t b, output answer_t a);
    int q, x0, x1, y0, y1, yr;
    longint num;
    logic [1:0] st;
    a = '0;
    if (b.op == OP_LOAD) begin
      if (bp_n < Depth) begin
        bp_x[bp_n] = $signed(b.xv);
        bp_y[bp_n] = $signed(b.yv);
        bp_n++;
        bp_sorted = 1'b0;
      end
      return 1'b0;
    end
    if (!bp_sorted) begin
      order_table();
      bp_sorted = 1'b1;
    end
    q = $signed(b.xv);
    yr = 0;
    if (bp_n == 0 || q < bp_x[0] || q > bp_x[bp_n-1]) st = ST_RANGE;
    else begin
      st = ST_NOSEG;
      for (int i = 0; i + 1 < bp_n; i++) begin
        x0 = bp_x[i]; x1 = bp_x[i+1];
        if (q >= x0 && q <= x1) begin
          y0 = bp_y[i]; y1 = bp_y[i+1];
          if (x0 == x1) yr = y0;
          else begin
            num = longint'(q - x0) * longint'(y1 - y0);
            yr = y0 + int'(num / longint'(x1 - x0));
          end
          st = ST_OK;
          break;
        end
      end
    end
    a.st = st;
    a.yr = (st == ST_OK) ? yr[15:0] : 16'h0;
    return 1'b1;
  endfunction

  function automatic beat_t mk(logic op, int x, int y);
    beat_t b;
    b.op = op; b.xv = x[15:0]; b.yv = y[15:0];
    return b;
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
           (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3));
  endfunction

  task automatic push(beat_t b, bit fx = 0, answer_t a = '0);
    feed_q = {feed_q, b};
    fixed_q = {fixed_q, fx};
    fixed_ans_q = {fixed_ans_q, a};
  endtask

  // stimulus plan
  initial begin
    row_t dir[$];
    int n, lo, hi, x;
    bp_n = 0; bp_sorted = 1'b1;
    dir = '{
      '{mk(OP_QUERY, 0, 0), 1, '{16'h0, ST_RANGE}},
      '{mk(OP_LOAD, 256, 100), 0, '0},
      '{mk(OP_QUERY, 256, 0), 1, '{16'h0, ST_NOSEG}},
      '{mk(OP_QUERY, 257, 0), 1, '{16'h0, ST_RANGE}},
      '{mk(OP_LOAD, -32768, -32768), 0, '0},
      '{mk(OP_LOAD, 32767, 32767), 0, '0},
      '{mk(OP_LOAD, 256, 4000), 0, '0},
      '{mk(OP_QUERY, -32768, 16'hffff), 1, '{16'h8000, ST_OK}},
      '{mk(OP_QUERY, 32767, 0), 1, '{16'h7fff, ST_OK}},
      '{mk(OP_QUERY, 256, 0), 1, '{16'd100, ST_OK}},
      '{mk(OP_QUERY, -1000, 0), 0, '0},
      '{mk(OP_QUERY, 20000, 0), 0, '0},
      '{mk(OP_QUERY, 300, 0), 0, '0}
    };
    foreach (dir[i]) push(dir[i].b, dir[i].fixed, dir[i].ans);
    // fill to capacity and beyond; the extra loads must be dropped
    for (int i = 0; i < Depth; i++)
      push(mk(OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 65535)));
    for (int i = 0; i < 4; i++) push(mk(OP_QUERY, $urandom_range(0, 65535), 0));
    for (int i = 0; i < 4; i++) push(mk(OP_QUERY, 32767, 0));
    // random part: bursts of loads (dropped once full) and queries, in-range mostly
    n = 0;
    while (n < 615) begin
      push(mk(OP_LOAD, 0, 0));
      n++;
      lo = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 6);
      hi = $urandom_range(1, 8);
      for (int i = 0; i < lo; i++) begin
        x = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 1023) - 512;
        push(mk(OP_LOAD, x, $urandom_range(0, 65535))); n++;
      end
      for (int i = 0; i < hi; i++) begin
        x = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                        : $urandom_range(0, 1100) - 550;
        push(mk(OP_QUERY, x, $urandom_range(0, 65535))); n++;
      end
    end
  end

  // sender
  initial begin
    beat_t b;
    answer_t a;
    int gap;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    while (feed_q.size() > 0) begin
      b = feed_q.pop_front();
      gap = short_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= b.op;
      s_axis_tdata  <= {b.yv, b.xv};
      do @(posedge clk); while (!s_axis_tready);
      if (interpolate(b, a))
        pending_q = {pending_q, fixed_q[0] ? fixed_ans_q[0] : a};
      void'(fixed_q.pop_front()); void'(fixed_ans_q.pop_front());
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver with one long hold-off once queries flow
  initial begin
    int cnt;
    cnt = 0;
    forever begin
      @(negedge clk);
      cnt++;
      if (cnt > 6000 && cnt < 7200) m_axis_tready <= 1'b0;
      else if (($urandom_range(0, 9)) < 3) m_axis_tready <= 1'b0;
      else m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    answer_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %h/%h", m_axis_tdata, m_axis_tuser);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata !== e.yr || m_axis_tuser !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: y exp %h got %h, status exp %0d got %0d",
                     e.yr, m_axis_tdata, e.st, m_axis_tuser);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
+incdir+sv
sv/btli_pkg.sv
sv/btli_div.sv
sv/btli_seq.sv
sv/breakpoint_table_linear_interp_unit.sv
sv/btli_chk.sv
dv/tb.sv
